[sv/racc_pkg.sv]
// Shared types and constants of the room appliance controller.
// Used by racc_step and room_appliance_controller_core; depends on nothing.
`timescale 1ns / 1ps

package racc_pkg;

    // Sample width and field layout.
    localparam int SAMPLE_BITS  = 10;
    localparam int ADC_W        = 10;
    localparam int BYTE_W       = 8;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 8;
    localparam int TEMP_W       = SAMPLE_BITS - 2;
    localparam int CMP_W        = SAMPLE_BITS + 1;

    // Reset values.
    localparam logic [7:0] TARGET_RESET = 8'd24;
    localparam logic [7:0] TPC_RESET    = 8'd10;

    // Command byte codes.
    localparam logic [7:0] CMD_STATUS_FIRST = 8'd0;
    localparam logic [7:0] CMD_STATUS_LAST  = 8'd5;
    localparam logic [7:0] CMD_ON_FIRST     = 8'd6;
    localparam logic [7:0] CMD_ON_LAST      = 8'd11;
    localparam logic [7:0] CMD_OFF_FIRST    = 8'd12;
    localparam logic [7:0] CMD_OFF_LAST     = 8'd17;
    localparam logic [7:0] CMD_SET_TEMP     = 8'd18;

    // Device index of the cooler and the TV; lamps are 0 to 3.
    localparam logic [2:0] DEV_COOLER = 3'd4;
    localparam logic [2:0] DEV_TV     = 3'd5;

    // Item kinds carried in tuser.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_DISCARD = 2'd1,
        PEND_SETTEMP = 2'd2
    } pend_t;

    typedef enum logic [1:0] {
        REPLY_ACK = 2'd0,
        REPLY_OFF = 2'd1,
        REPLY_ON  = 2'd2
    } reply_t;

    // Complete controller state.
    typedef struct packed {
        logic [3:0] lamp_bits;
        logic       cooler_bit;
        logic       tv_bit;
        logic [7:0] target_temperature;
        logic [7:0] tick_count;
        logic       last_decision;
        logic       ticks_enabled;
        pend_t      pending_mode;
        reply_t     loaded_reply;
    } ctrl_state_t;

    localparam ctrl_state_t STATE_RESET = '{
        lamp_bits:          4'd0,
        cooler_bit:         1'b0,
        tv_bit:             1'b0,
        target_temperature: TARGET_RESET,
        tick_count:         8'd0,
        last_decision:      1'b0,
        ticks_enabled:      1'b1,
        pending_mode:       PEND_NONE,
        loaded_reply:       REPLY_ACK
    };

endpackage

[sv/racc_step.sv]
// Next-state logic of the room appliance controller for one item.
// Depends on racc_pkg for the state type and the command codes.
`timescale 1ns / 1ps

module racc_step (
    input  racc_pkg::ctrl_state_t         state_cur,
    input  logic                          kind,
    input  logic [7:0]                    rx_byte,
    input  logic [racc_pkg::ADC_W-1:0]    adc_sample,
    input  logic [7:0]                    ticks_per_check,
    output racc_pkg::ctrl_state_t         state_nxt
);
    import racc_pkg::*;

    logic [2:0]             dev_idx;
    logic                   dev_bit;
    logic [7:0]             cnt_inc;
    logic [TEMP_W-1:0]      temp;
    logic signed [CMP_W-1:0] temp_s;
    logic signed [CMP_W-1:0] target_s;

    // Status bit of the device named by a status command.
    assign dev_idx = rx_byte[2:0];
    always_comb begin
        if (dev_idx == DEV_COOLER) begin
            dev_bit = state_cur.cooler_bit;
        end else if (dev_idx == DEV_TV) begin
            dev_bit = state_cur.tv_bit;
        end else begin
            dev_bit = state_cur.lamp_bits[dev_idx[1:0]];
        end
    end

    // Thermostat operands: sample over four against the signed target.
    assign cnt_inc  = state_cur.tick_count + 8'd1;
    assign temp     = adc_sample[SAMPLE_BITS-1:2];
    assign temp_s   = signed'({{(CMP_W-TEMP_W){1'b0}}, temp});
    assign target_s = signed'({{(CMP_W-8){state_cur.target_temperature[7]}},
                               state_cur.target_temperature});

    always_comb begin
        logic [2:0] sel;
        logic       on_val;
        logic       do_set;
        state_nxt = state_cur;
        sel       = 3'd0;
        on_val    = 1'b0;
        do_set    = 1'b0;
        if (kind == KIND_BYTE) begin
            // Serial byte: pending transfer first, then command decode.
            if (state_cur.pending_mode == PEND_DISCARD) begin
                state_nxt.pending_mode = PEND_NONE;
                state_nxt.loaded_reply = REPLY_ACK;
            end else if (state_cur.pending_mode == PEND_SETTEMP) begin
                state_nxt.pending_mode       = PEND_NONE;
                state_nxt.target_temperature = rx_byte;
                state_nxt.loaded_reply       = REPLY_ACK;
            end else begin
                state_nxt.loaded_reply = REPLY_ACK;
                if (rx_byte inside {[CMD_STATUS_FIRST:CMD_STATUS_LAST]}) begin
                    state_nxt.loaded_reply = dev_bit ? REPLY_ON : REPLY_OFF;
                    state_nxt.pending_mode = PEND_DISCARD;
                end else if (rx_byte inside {[CMD_ON_FIRST:CMD_ON_LAST]}) begin
                    sel    = 3'(rx_byte - CMD_ON_FIRST);
                    on_val = 1'b1;
                    do_set = 1'b1;
                end else if (rx_byte inside {[CMD_OFF_FIRST:CMD_OFF_LAST]}) begin
                    sel    = 3'(rx_byte - CMD_OFF_FIRST);
                    on_val = 1'b0;
                    do_set = 1'b1;
                end else if (rx_byte == CMD_SET_TEMP) begin
                    state_nxt.pending_mode = PEND_SETTEMP;
                end
            end
            // Device switching; the cooler also gates tick counting.
            if (do_set) begin
                if (sel == DEV_COOLER) begin
                    state_nxt.cooler_bit    = on_val;
                    state_nxt.ticks_enabled = on_val;
                end else if (sel == DEV_TV) begin
                    state_nxt.tv_bit = on_val;
                end else begin
                    state_nxt.lamp_bits[sel[1:0]] = on_val;
                end
            end
        end else if (state_cur.ticks_enabled) begin
            // Counted tick: check the thermostat once the count is reached.
            if (cnt_inc < ticks_per_check) begin
                state_nxt.tick_count = cnt_inc;
            end else begin
                state_nxt.tick_count = 8'd0;
                if (temp_s > target_s) begin
                    state_nxt.cooler_bit    = 1'b1;
                    state_nxt.last_decision = 1'b1;
                end else if (temp_s < target_s) begin
                    state_nxt.cooler_bit    = 1'b0;
                    state_nxt.last_decision = 1'b0;
                end else begin
                    state_nxt.cooler_bit = state_cur.last_decision;
                end
            end
        end
    end

endmodule

[sv/room_appliance_controller_core.sv]
// Top level of the room appliance controller: input register, state, result register.
// Depends on racc_pkg and racc_step.
`timescale 1ns / 1ps

// Room appliance controller core.
// The s_ stream carries one beat per serial command byte or timer tick; tuser
// gives the kind (0 byte, 1 tick), tdata the byte and the converter sample.
// The m_ stream returns exactly one beat per input beat: the reply loaded for
// the next transfer, the four lamp drives, the cooler drive and the TV drive,
// all as they stand after that item.
// The cfg_ channel writes ticks_per_check; it is always ready. The user must
// write it only while the block is idle; the block itself does not enforce this.
// An input beat goes into an input register, its result is computed in one
// pass of decode and compare logic and lands in the output register, from
// which it is offered on m_. One beat per cycle is sustained in both
// directions while the receiver does not stall.
// When the receiver stalls, the output register holds its beat and the input
// register still takes one more beat; s_tready then drops until m_tready
// returns.
// Reset (aresetn low, synchronous) empties both registers, turns every device
// off, sets the target to 24, the check interval to 10 and enables counting.
module room_appliance_controller_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [racc_pkg::IN_DATA_W-1:0]    s_tdata,  // rx_byte[7:0], adc_sample[17:8]
    input  logic                              s_tuser,  // cmd (item kind)
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [racc_pkg::OUT_DATA_W-1:0]   m_tdata,  // reply_code[1:0], room_lamps[5:2],
                                                        // cooling_on[6], tv_on[7]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [7:0]                        cfg_data
);
    import racc_pkg::*;

    logic                   in_valid_reg;
    logic                   in_kind_reg;
    logic [BYTE_W-1:0]      in_byte_reg;
    logic [ADC_W-1:0]       in_adc_reg;
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [7:0]             tpc_reg;
    ctrl_state_t            state_reg;
    ctrl_state_t            state_next;
    logic                   advance;

    // The input stage moves on when the output register is free or being taken.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    racc_step u_step (
        .state_cur       (state_reg),
        .kind            (in_kind_reg),
        .rx_byte         (in_byte_reg),
        .adc_sample      (in_adc_reg),
        .ticks_per_check (tpc_reg),
        .state_nxt       (state_next)
    );

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpc_reg <= TPC_RESET;
        end else if (cfg_valid && cfg_ready) begin
            tpc_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_adc_reg  <= s_tdata[BYTE_W+ADC_W-1:BYTE_W];
        end
    end

    // Controller state, updated once per processed beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {state_next.tv_bit, state_next.cooler_bit,
                             state_next.lamp_bits, state_next.loaded_reply};
        end
    end

endmodule

[tb/testbench.sv]
// Self-checking testbench for room_appliance_controller_core: command bytes and
// timer ticks are streamed in and every result beat is checked against a local predictor.
// Depends on racc_pkg and the RTL of the core.
`timescale 1ns / 1ps

module testbench;
    import racc_pkg::*;

    localparam int CYCLE_LIMIT = 100000;

    // One input item as the generator builds it; hold makes the sender wait for a drain.
    typedef struct {
        logic       kind;
        logic [7:0] rx_byte;
        logic [9:0] adc_sample;
        bit         hold;
    } stim_item_t;

    // Outputs the block should show after one item.
    typedef struct packed {
        reply_t     reply;
        logic [3:0] lamps;
        logic       cool;
        logic       tv;
    } panel_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [7:0]            cfg_data  = 8'd0;

    stim_item_t  stim_q[$];
    panel_t      panel_q[$];
    stim_item_t  offered;
    ctrl_state_t room_st = STATE_RESET;
    logic [7:0]  tpc_model = TPC_RESET;
    logic [7:0]  gen_target = TARGET_RESET;
    int          in_flight = 0;
    int          sent_beats = 0;
    int          rx_beats = 0;
    int          hold_cycles = 0;
    bit          stall_done = 0;
    int          fails = 0;
    int          cycles = 0;

    room_appliance_controller_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // rx_byte[7:0], adc_sample[17:8]
        .s_tuser   (s_tuser),   // cmd (item kind)
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // reply_code[1:0], room_lamps[5:2], cooling_on[6], tv_on[7]
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Advance the predicted controller state by one item and return the outputs it shows.
    function automatic panel_t apply_item(input stim_item_t it);
        logic [7:0]        b;
        logic [7:0]        idx;
        logic [2:0]        dev;
        logic              on;
        logic              bit_now;
        logic signed [9:0] temp;
        logic signed [9:0] tgt;
        panel_t            p;
        b = it.rx_byte;
        if (it.kind == KIND_BYTE) begin
            if (room_st.pending_mode == PEND_DISCARD) begin
                // The transfer that carries a status reply discards its byte.
                room_st.pending_mode = PEND_NONE;
                room_st.loaded_reply = REPLY_ACK;
            end else if (room_st.pending_mode == PEND_SETTEMP) begin
                room_st.pending_mode       = PEND_NONE;
                room_st.target_temperature = b;
                room_st.loaded_reply       = REPLY_ACK;
            end else begin
                room_st.loaded_reply = REPLY_ACK;
                if (b <= CMD_STATUS_LAST) begin
                    dev = b[2:0];
                    case (dev)
                        DEV_COOLER: bit_now = room_st.cooler_bit;
                        DEV_TV:     bit_now = room_st.tv_bit;
                        default:    bit_now = room_st.lamp_bits[dev[1:0]];
                    endcase
                    if (bit_now)
                        room_st.loaded_reply = REPLY_ON;
                    else
                        room_st.loaded_reply = REPLY_OFF;
                    room_st.pending_mode = PEND_DISCARD;
                end else if (b <= CMD_OFF_LAST) begin
                    on  = (b <= CMD_ON_LAST);
                    idx = on ? b - CMD_ON_FIRST : b - CMD_OFF_FIRST;
                    dev = idx[2:0];
                    // The cooler command also starts or stops tick counting.
                    case (dev)
                        DEV_COOLER: begin
                            room_st.cooler_bit    = on;
                            room_st.ticks_enabled = on;
                        end
                        DEV_TV:  room_st.tv_bit = on;
                        default: room_st.lamp_bits[dev[1:0]] = on;
                    endcase
                end else if (b == CMD_SET_TEMP) begin
                    room_st.pending_mode = PEND_SETTEMP;
                end
            end
        end else if (room_st.ticks_enabled) begin
            room_st.tick_count = room_st.tick_count + 8'd1;
            if (room_st.tick_count >= tpc_model) begin
                room_st.tick_count = 8'd0;
                // Hysteresis check of sample/4 against the signed target.
                temp = {2'b00, it.adc_sample[SAMPLE_BITS-1:2]};
                tgt  = {{2{room_st.target_temperature[7]}}, room_st.target_temperature};
                if (temp > tgt) begin
                    room_st.cooler_bit    = 1'b1;
                    room_st.last_decision = 1'b1;
                end else if (temp < tgt) begin
                    room_st.cooler_bit    = 1'b0;
                    room_st.last_decision = 1'b0;
                end else begin
                    room_st.cooler_bit = room_st.last_decision;
                end
            end
        end
        p.reply = room_st.loaded_reply;
        p.lamps = room_st.lamp_bits;
        p.cool  = room_st.cooler_bit;
        p.tv    = room_st.tv_bit;
        return p;
    endfunction

    task automatic add_item(input logic kind, input logic [7:0] b, input logic [9:0] s);
        stim_item_t it;
        it.kind       = kind;
        it.rx_byte    = b;
        it.adc_sample = s;
        it.hold       = 1'b0;
        stim_q.push_back(it);
    endtask

    // The unused field of each item is random so that it is seen to be ignored.
    task automatic add_byte(input logic [7:0] b);
        logic [9:0] s;
        s = 10'($urandom_range(1023));
        add_item(KIND_BYTE, b, s);
    endtask

    task automatic add_tick(input logic [9:0] s);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        add_item(KIND_TICK, b, s);
    endtask

    // Samples mostly land close to the target so that all three compare outcomes occur.
    function automatic logic [9:0] near_sample();
        int         v;
        logic [9:0] s;
        if (gen_target[7] || $urandom_range(4) == 0) begin
            s = 10'($urandom_range(1023));
            return s;
        end
        v = gen_target;
        v = v * 4 + $urandom_range(11) - 4;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        s = v[9:0];
        return s;
    endfunction

    // Random part: mostly well-formed command sequences and tick bursts, plus some noise.
    task automatic build_random(input int n_items, input int max_burst);
        int pick;
        int len;
        while (stim_q.size() < n_items) begin
            pick = $urandom_range(99);
            if (pick < 14) begin
                add_byte(8'($urandom_range(CMD_STATUS_LAST)));
                if ($urandom_range(3) == 0)
                    add_tick(near_sample());
                add_byte(8'($urandom_range(255)));
            end else if (pick < 26) begin
                add_byte(CMD_SET_TEMP);
                if ($urandom_range(2) == 0)
                    gen_target = 8'($urandom_range(255));
                else
                    gen_target = 8'($urandom_range(70));
                if ($urandom_range(3) == 0)
                    add_tick(near_sample());
                add_byte(gen_target);
            end else if (pick < 40) begin
                if ($urandom_range(3) == 0)
                    add_byte(CMD_ON_FIRST + DEV_COOLER);
                else
                    add_byte(8'($urandom_range(CMD_OFF_LAST, CMD_ON_FIRST)));
            end else if (pick < 88) begin
                len = $urandom_range(max_burst, 1);
                repeat (len) add_tick(near_sample());
            end else if (pick < 95) begin
                add_byte(8'($urandom_range(255, CMD_SET_TEMP + 1)));
            end else begin
                add_byte(8'($urandom_range(255)));
            end
            if ($urandom_range(39) == 0)
                stim_q[$].hold = 1'b1;
        end
    endtask

    // Register write over the config channel; only called while the block is idle.
    task automatic write_tpc(input logic [7:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tpc_model = v;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        while (stim_q.size() != 0 || s_tvalid || in_flight != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    // Sender: offers queued items, predicts each accepted beat, and counts results in flight.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            room_st    = STATE_RESET;
            in_flight  = 0;
            sent_beats = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                panel_q.push_back(apply_item(offered));
                in_flight++;
                sent_beats++;
            end
            if (m_tvalid && m_tready)
                in_flight--;
            if (!s_tvalid || s_tready) begin
                if (stim_q.size() == 0 || (stim_q[0].hold && in_flight != 0) ||
                    (!(sent_beats >= 500 && sent_beats < 700) && $urandom_range(99) < 13)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    offered  = stim_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'd0, offered.adc_sample, offered.rx_byte};
                    s_tuser  <= offered.kind;
                end
            end
        end
    end

    // Receiver ready: random idling, one long hold-off, and a stretch that is always ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                rx_beats++;
            if (hold_cycles != 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else if (rx_beats == 300 && !stall_done) begin
                stall_done  = 1;
                hold_cycles = 400;
                m_tready <= 1'b0;
            end else if (rx_beats >= 500 && rx_beats < 700) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 13);
            end
        end
    end

    // Result checker: each result beat is compared with the oldest prediction.
    always @(posedge aclk) begin
        panel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (panel_q.size() == 0) begin
                $error("result beat with no expected outputs waiting");
                fails++;
            end else begin
                want = panel_q.pop_front();
                check_field("reply_code", 4'(want.reply), 4'(m_tdata[1:0]));
                check_field("room_lamps", want.lamps, m_tdata[5:2]);
                check_field("cooling_on", 4'(want.cool), 4'(m_tdata[6]));
                check_field("tv_on", 4'(want.tv), 4'(m_tdata[7]));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part with a check on every counted tick.
        write_tpc(8'd1);
        add_byte(CMD_STATUS_FIRST);          // room 1 is off
        add_byte(8'hFF);                     // reply transfer, discarded
        add_byte(CMD_ON_FIRST);
        add_byte(CMD_STATUS_FIRST);          // room 1 is on
        add_tick(10'd1023);                  // tick while a reply is pending
        add_byte(CMD_SET_TEMP);              // discarded even though it is a command
        add_byte(CMD_ON_FIRST + 8'd1);
        add_byte(CMD_ON_FIRST + 8'd2);
        add_byte(CMD_ON_FIRST + 8'd3);
        add_byte(CMD_ON_FIRST + DEV_COOLER);
        add_byte(CMD_ON_LAST);
        add_byte(CMD_SET_TEMP);
        add_byte(8'h80);                     // most negative target
        add_tick(10'd0);
        add_byte(CMD_SET_TEMP);
        add_byte(8'd100);
        add_tick(10'd402);                   // equal: keep last decision (on)
        add_tick(10'd0);
        add_tick(10'd401);                   // equal: keep last decision (off)
        add_byte(CMD_OFF_FIRST + DEV_COOLER);
        add_tick(10'd1023);                  // counting disabled
        add_byte(CMD_SET_TEMP + 8'd1);       // unknown codes
        add_byte(8'hFF);
        add_byte(CMD_OFF_FIRST);
        wait_idle();

        write_tpc(8'd255);
        gen_target = TARGET_RESET;
        build_random(350, 120);
        wait_idle();

        write_tpc(TPC_RESET);
        build_random(200, 15);
        wait_idle();

        write_tpc(8'($urandom_range(40, 2)));
        build_random(250, 20);
        wait_idle();

        write_tpc(8'd1);
        build_random(250, 6);
        wait_idle();

        if (panel_q.size() != 0) begin
            $error("%0d expected results never arrived", panel_q.size());
            fails++;
        end
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
